FILE: rtl/assert_macros.svh
// Assertion helper macros used by the queue controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/rrgtq_pkg.sv
package rrgtq_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int MAX_TASKS  = 64;
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int TW = $clog2(MAX_TASKS);
    localparam int GCW = $clog2(MAX_GROUPS + 1);

    typedef enum logic [1:0] {
        K_CREATE = 2'd0,
        K_REMOVE = 2'd1,
        K_LOOKUP = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] group_id;
        logic [21:0] task_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_group;
    } t_out;

    // Group table entry: identifier and FIFO head and tail task slots.
    typedef struct packed {
        logic [31:0]   ident;
        logic [TW-1:0] first;
        logic [TW-1:0] last;
    } t_grp;

    // Task table entry: identifier and next slot in the same FIFO.
    typedef struct packed {
        logic [21:0]   ident;
        logic [TW-1:0] link;
    } t_tsk;

    // Memory access bundle from the sequencer to the storage.
    typedef struct packed {
        logic          g_we;
        logic [GW-1:0] g_waddr;
        t_grp          g_wdata;
        logic [GW-1:0] g_raddr;
        logic          r_we;
        logic [GW-1:0] r_waddr;
        logic [GW-1:0] r_wdata;
        logic [GW-1:0] r_raddr;
        logic          t_we;
        logic [TW-1:0] t_waddr;
        t_tsk          t_wdata;
        logic [TW-1:0] t_raddr;
    } t_mem_req;

    typedef struct packed {
        t_grp          g_rdata;
        logic [GW-1:0] r_rdata;
        t_tsk          t_rdata;
    } t_mem_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSCAN,
        S_CSCAN_W,
        S_CFREE,
        S_CNEW,
        S_CAPP,
        S_RRING,
        S_RGRP,
        S_RTASK,
        S_LRING,
        S_LGRP,
        S_LTASK,
        S_DONE
    } t_state;

endpackage

FILE: rtl/round_robin_group_task_queue.sv
// Round-robin queue of task FIFOs, one FIFO per group.
// Input channel i_valid/o_ready carries one t_in beat: kind, group_id, task_id.
// Output channel o_valid/i_ready returns exactly one t_out beat per input beat.
// Items are handled one at a time; a new beat is taken only once the previous
// result has been taken by the receiver, at the earliest in the cycle after.
// Steps, each issuing registered memory reads in the sequencer:
//   remove: head ring slot, then group entry, then head task; unused kind
//   or empty ring: answered from idle with no memory read.
//   create: ring groups are scanned until a hit (ring slot, then group entry),
//   then free task and group slots are searched, then the result is issued.
//   Appending to an existing group then reads back and rewrites the
//   previous tail before the next beat can be accepted.
//   lookup: each ring group in turn, then each task of its FIFO.
// Reset (synchronous, active low) empties the ring and frees all group and
// task slots at once through valid bits; no clearing pass is needed.
// When the receiver stalls, the result is held and no new beat is accepted.
module round_robin_group_task_queue
    import rrgtq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    rrgtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .o_req   (mem_req),
        .i_rsp   (mem_rsp)
    );

    rrgtq_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule

FILE: rtl/rrgtq_store.sv
module rrgtq_store
    import rrgtq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    t_grp          group_mem [MAX_GROUPS];
    logic [GW-1:0] ring_mem  [MAX_GROUPS];
    t_tsk          task_mem  [MAX_TASKS];

    // Group table, ring of group slots and task table: each has one write
    // and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.g_we) begin
            group_mem[i_req.g_waddr] <= i_req.g_wdata;
        end
        if (i_req.r_we) begin
            ring_mem[i_req.r_waddr] <= i_req.r_wdata;
        end
        if (i_req.t_we) begin
            task_mem[i_req.t_waddr] <= i_req.t_wdata;
        end
        o_rsp.g_rdata <= group_mem[i_req.g_raddr];
        o_rsp.r_rdata <= ring_mem[i_req.r_raddr];
        o_rsp.t_rdata <= task_mem[i_req.t_raddr];
    end

endmodule

FILE: rtl/rrgtq_ctrl.sv
module rrgtq_ctrl
    import rrgtq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in      i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out     o_data,
    output t_mem_req o_req,
    input  t_mem_rsp i_rsp
);

    `include "assert_macros.svh"

    t_state                r_state, n_state;
    t_in                   r_cmd, n_cmd;
    logic [MAX_GROUPS-1:0] r_gvalid, n_gvalid;
    logic [MAX_TASKS-1:0]  r_tused, n_tused;
    logic [GW-1:0]         r_front, n_front;
    logic [GCW-1:0]        r_size, n_size;
    logic [GCW-1:0]        r_idx, n_idx;
    logic [GW-1:0]         r_gslot, n_gslot;
    t_grp                  r_grp, n_grp;
    logic [TW-1:0]         r_tslot, n_tslot;
    logic [TW:0]           r_tcnt, n_tcnt;
    logic                  r_found, n_found;
    logic [TW-1:0]         r_fslot, n_fslot;
    logic                  r_tfree, n_tfree;
    logic [GW-1:0]         r_fgslot, n_fgslot;
    logic                  r_gfree, n_gfree;
    logic [TW:0]           r_scan, n_scan;
    logic                  r_ovalid, n_ovalid;
    t_out                  r_out, n_out;

    logic [GW-1:0] ring_pos;
    logic [GW-1:0] tail_pos;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign ring_pos = r_front + r_idx[GW-1:0];
    assign tail_pos = r_front + r_size[GW-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gvalid <= '0;
            r_tused  <= '0;
            r_front  <= '0;
            r_size   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gvalid <= n_gvalid;
            r_tused  <= n_tused;
            r_front  <= n_front;
            r_size   <= n_size;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_gslot  <= n_gslot;
        r_grp    <= n_grp;
        r_tslot  <= n_tslot;
        r_tcnt   <= n_tcnt;
        r_found  <= n_found;
        r_fslot  <= n_fslot;
        r_tfree  <= n_tfree;
        r_fgslot <= n_fgslot;
        r_gfree  <= n_gfree;
        r_scan   <= n_scan;
        r_out    <= n_out;
    end

    // Sequencer: each step issues reads whose data returns the next cycle.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_gvalid = r_gvalid;
        n_tused  = r_tused;
        n_front  = r_front;
        n_size   = r_size;
        n_idx    = r_idx;
        n_gslot  = r_gslot;
        n_grp    = r_grp;
        n_tslot  = r_tslot;
        n_tcnt   = r_tcnt;
        n_found  = r_found;
        n_fslot  = r_fslot;
        n_tfree  = r_tfree;
        n_fgslot = r_fgslot;
        n_gfree  = r_gfree;
        n_scan   = r_scan;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        o_req    = '0;
        o_req.r_raddr = ring_pos;
        o_req.g_raddr = i_rsp.r_rdata;
        o_req.t_raddr = r_tslot;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd   = i_data;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_scan  = '0;
                    n_tfree = 1'b0;
                    n_gfree = 1'b0;
                    unique case (t_kind'(i_data.kind))
                        K_CREATE: n_state = S_CSCAN;
                        K_REMOVE: begin
                            if (r_size == '0) begin
                                n_out    = '{status: ST_EMPTY, found_group: '0};
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_RRING;
                            end
                        end
                        K_LOOKUP: n_state = S_LRING;
                        default: begin
                            n_out    = '{status: ST_OK, found_group: '0};
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end

            // Create: ring slot read issued for the group at the scan index.
            S_CSCAN: begin
                if (r_idx >= r_size) begin
                    n_state = S_CFREE;
                end else begin
                    n_state = S_CSCAN_W;
                end
                o_req.r_raddr = ring_pos;
            end

            S_CSCAN_W: begin
                // Ring data is valid now; group read issued with it.
                n_gslot = i_rsp.r_rdata;
                n_state = S_CAPP;
                o_req.g_raddr = i_rsp.r_rdata;
            end

            S_CAPP: begin
                if (r_found) begin
                    // Group hit; append after free slot search.
                    n_state = S_CFREE;
                end else if (r_gvalid[r_gslot] && i_rsp.g_rdata.ident == r_cmd.group_id) begin
                    n_found = 1'b1;
                    n_grp   = i_rsp.g_rdata;
                    n_state = S_CFREE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CSCAN;
                end
            end

            // Find lowest free task and group slots, one index per cycle.
            S_CFREE: begin
                if (!r_tfree && r_scan < (TW+1)'(MAX_TASKS)) begin
                    if (!r_tused[r_scan[TW-1:0]]) begin
                        n_tfree = 1'b1;
                        n_fslot = r_scan[TW-1:0];
                    end
                end
                if (!r_gfree && r_scan < (TW+1)'(MAX_GROUPS)) begin
                    if (!r_gvalid[r_scan[GW-1:0]]) begin
                        n_gfree  = 1'b1;
                        n_fgslot = r_scan[GW-1:0];
                    end
                end
                n_scan = r_scan + 1'b1;
                if (r_scan >= (TW+1)'(MAX_TASKS - 1) || (n_tfree && (n_gfree || r_found))) begin
                    n_state = S_CNEW;
                end
            end

            S_CNEW: begin
                n_out    = '{status: ST_OK, found_group: '0};
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
                if (!r_tfree) begin
                    n_out.status = ST_FULL;
                end else if (!r_found && (!r_gfree || r_size >= GCW'(MAX_GROUPS))) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_tused[r_fslot] = 1'b1;
                    o_req.t_we    = 1'b1;
                    o_req.t_waddr = r_fslot;
                    o_req.t_wdata = '{ident: r_cmd.task_id, link: r_fslot};
                    o_req.g_we    = 1'b1;
                    if (r_found) begin
                        o_req.g_waddr = r_gslot;
                        o_req.g_wdata = '{ident: r_grp.ident, first: r_grp.first,
                                          last: r_fslot};
                        n_tslot = r_grp.last;
                        n_tcnt  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_gvalid[r_fgslot] = 1'b1;
                        o_req.g_waddr = r_fgslot;
                        o_req.g_wdata = '{ident: r_cmd.group_id, first: r_fslot,
                                          last: r_fslot};
                        o_req.r_we    = 1'b1;
                        o_req.r_waddr = tail_pos;
                        o_req.r_wdata = r_fgslot;
                        n_size = r_size + 1'b1;
                    end
                end
            end

            // Link previous tail to the new task: read it back then rewrite.
            S_DONE: begin
                o_req.t_we    = 1'b1;
                o_req.t_waddr = r_tslot;
                o_req.t_wdata = '{ident: i_rsp.t_rdata.ident, link: r_fslot};
                n_state = (r_cmd.kind == K_CREATE && r_tcnt == '0) ? S_DONE : S_IDLE;
                if (r_tcnt == '0) begin
                    // First visit only waits for the read.
                    o_req.t_we = 1'b0;
                    n_tcnt = (TW+1)'(1);
                end else begin
                    n_tcnt = '0;
                end
                o_req.t_raddr = r_tslot;
            end

            // Remove: read head ring slot, then group entry.
            S_RRING: begin
                o_req.r_raddr = r_front;
                n_state = S_RGRP;
            end

            S_RGRP: begin
                n_gslot = i_rsp.r_rdata;
                o_req.g_raddr = i_rsp.r_rdata;
                n_state = S_RTASK;
                n_tcnt  = '0;
            end

            S_RTASK: begin
                if (r_tcnt == '0) begin
                    n_grp   = i_rsp.g_rdata;
                    n_tslot = i_rsp.g_rdata.first;
                    n_tcnt  = (TW+1)'(1);
                end else begin
                    n_tused[r_grp.first] = 1'b0;
                    n_out    = '{status: ST_OK, found_group: r_grp.ident};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    n_front  = r_front + 1'b1;
                    if (r_grp.first == r_grp.last) begin
                        n_gvalid[r_gslot] = 1'b0;
                        n_size = r_size - 1'b1;
                    end else begin
                        o_req.g_we    = 1'b1;
                        o_req.g_waddr = r_gslot;
                        o_req.g_wdata = '{ident: r_grp.ident, first: i_rsp.t_rdata.link,
                                          last: r_grp.last};
                        o_req.r_we    = 1'b1;
                        o_req.r_waddr = tail_pos;
                        o_req.r_wdata = r_gslot;
                    end
                end
                o_req.t_raddr = n_tslot;
            end

            // Lookup: walk the ring, and each group's FIFO.
            S_LRING: begin
                if (r_idx >= r_size) begin
                    n_out    = '{status: ST_NOT_FOUND, found_group: '0};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_req.r_raddr = ring_pos;
                    n_state = S_LGRP;
                    n_tcnt  = '0;
                end
            end

            S_LGRP: begin
                if (r_tcnt == '0) begin
                    o_req.g_raddr = i_rsp.r_rdata;
                    n_gslot = i_rsp.r_rdata;
                    n_tcnt  = (TW+1)'(1);
                end else begin
                    n_grp   = i_rsp.g_rdata;
                    n_tslot = i_rsp.g_rdata.first;
                    o_req.t_raddr = i_rsp.g_rdata.first;
                    n_tcnt  = '0;
                    n_state = S_LTASK;
                end
            end

            S_LTASK: begin
                if (r_tused[r_tslot] && i_rsp.t_rdata.ident == r_cmd.task_id) begin
                    n_out    = '{status: ST_OK, found_group: r_grp.ident};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_tslot == r_grp.last || r_tcnt == (TW+1)'(MAX_TASKS - 1)) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LRING;
                end else begin
                    n_tslot = i_rsp.t_rdata.link;
                    o_req.t_raddr = i_rsp.t_rdata.link;
                    n_tcnt  = r_tcnt + 1'b1;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_CLK(a_size_range, i_clk, i_rst_n, r_size <= GCW'(MAX_GROUPS),
        "ring size exceeds group capacity")
    `ASSERT_CLK(a_busy_not_ready, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> !o_ready, "ready while busy")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_out)), "result dropped")
    `ASSERT_CLK(a_size_valid, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> (r_size == GCW'($countones(r_gvalid))),
        "ring size disagrees with valid groups")

endmodule

FILE: verif/round_robin_group_task_queue_checker.sv
`timescale 1ns / 100ps

module round_robin_group_task_queue_checker
    import rrgtq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready_in,
    input  t_in  i_data,
    input  logic i_out_valid,
    input  logic i_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_seen
);

    // Shadow copy of the queue state.
    logic        grp_used [MAX_GROUPS];
    logic [31:0] grp_name [MAX_GROUPS];
    int          grp_head [MAX_GROUPS];
    int          grp_tail [MAX_GROUPS];
    int          ring_order [MAX_GROUPS];
    int          ring_head;
    int          ring_count;
    logic [21:0] tsk_name [MAX_TASKS];
    int          tsk_next [MAX_TASKS];
    logic        tsk_used [MAX_TASKS];

    t_out answer_queue [$];

    function automatic int slot_at(int pos);
        return ring_order[(ring_head + pos) % MAX_GROUPS];
    endfunction

    // Create: append the task to its group, allocating the group if new.
    function automatic t_status add_task(logic [31:0] gid, logic [21:0] tid);
        int g;
        int t;
        g = -1;
        t = -1;
        for (int i = 0; i < ring_count; i++) begin
            if (grp_used[slot_at(i)] && grp_name[slot_at(i)] == gid) begin
                g = slot_at(i);
                break;
            end
        end
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (!tsk_used[i]) begin
                t = i;
                break;
            end
        end
        if (t < 0) return ST_FULL;
        if (g < 0) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                if (!grp_used[i]) begin
                    g = i;
                    break;
                end
            end
            if (g < 0 || ring_count >= MAX_GROUPS) return ST_FULL;
            grp_used[g] = 1'b1;
            grp_name[g] = gid;
            grp_head[g] = t;
            ring_order[(ring_head + ring_count) % MAX_GROUPS] = g;
            ring_count++;
        end else begin
            tsk_next[grp_tail[g]] = t;
        end
        tsk_used[t] = 1'b1;
        tsk_name[t] = tid;
        tsk_next[t] = t;
        grp_tail[g] = t;
        return ST_OK;
    endfunction

    // Remove: pop the head task of the head group and rotate or free it.
    function automatic t_status pop_task(output logic [31:0] gid);
        int g;
        int t;
        gid = '0;
        if (ring_count == 0) return ST_EMPTY;
        g = slot_at(0);
        gid = grp_name[g];
        t = grp_head[g];
        tsk_used[t] = 1'b0;
        if (t == grp_tail[g]) begin
            grp_used[g] = 1'b0;
            ring_count--;
        end else begin
            grp_head[g] = tsk_next[t];
            ring_order[(ring_head + ring_count) % MAX_GROUPS] = g;
        end
        ring_head = (ring_head + 1) % MAX_GROUPS;
        return ST_OK;
    endfunction

    // Lookup: walk the ring and each FIFO for the first holder.
    function automatic t_status find_task(logic [21:0] tid, output logic [31:0] gid);
        int g;
        int t;
        gid = '0;
        for (int i = 0; i < ring_count; i++) begin
            g = slot_at(i);
            t = grp_head[g];
            for (int n = 0; n < MAX_TASKS; n++) begin
                if (tsk_used[t] && tsk_name[t] == tid) begin
                    gid = grp_name[g];
                    return ST_OK;
                end
                if (t == grp_tail[g]) break;
                t = tsk_next[t];
            end
        end
        return ST_NOT_FOUND;
    endfunction

    function automatic t_out predict_answer(t_in beat);
        t_out r;
        logic [31:0] gid;
        t_status st;
        gid = '0;
        st = ST_OK;
        case (t_kind'(beat.kind))
            K_CREATE: st = add_task(beat.group_id, beat.task_id);
            K_REMOVE: st = pop_task(gid);
            K_LOOKUP: st = find_task(beat.task_id, gid);
            default: st = ST_OK;
        endcase
        r.status = st;
        r.found_group = (st == ST_OK) ? gid : '0;
        return r;
    endfunction

    // Track input beats, compare output beats.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_GROUPS; i++) grp_used[i] = 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) tsk_used[i] = 1'b0;
            ring_head = 0;
            ring_count = 0;
            answer_queue.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_valid && i_ready_in) answer_queue.push_back(predict_answer(i_data));
            if (i_out_valid && i_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (answer_queue.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_queue.pop_front();
                    if (want.status != i_out_data.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                            want.status, i_out_data.status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.found_group != i_out_data.found_group) begin
                        $display("%0t: found_group expected %h actual %h", $time,
                            want.found_group, i_out_data.found_group);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= answer_queue.size();
    end

endmodule

FILE: verif/round_robin_group_task_queue_test.sv
`timescale 1ns / 100ps

module round_robin_group_task_queue_test;
    import rrgtq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    int   fail_count;
    int   pending;
    int   results_seen;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_off = 1'b0;
    int   cycle_count = 0;
    int   items_sent = 0;
    logic [31:0] group_pool [8];

    always #6 i_clk = ~i_clk;

    round_robin_group_task_queue u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    round_robin_group_task_queue_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_data(i_data), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_out_data(o_data), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one beat, with an optional idle gap first, and wait for acceptance.
    // Valid drops only during an idle gap, so back-to-back beats keep it high.
    task automatic send_beat(t_kind k, logic [31:0] gid, logic [21:0] tid);
        t_in beat;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        beat.kind = k;
        beat.group_id = gid;
        beat.task_id = tid;
        i_valid <= 1'b1;
        i_data <= beat;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Mostly creates and removes over a small set of groups and task ids.
    task automatic random_beat();
        int r;
        logic [21:0] tid;
        r = $urandom_range(99);
        tid = ($urandom_range(3) == 0) ? 22'($urandom) : 22'($urandom_range(15));
        if (r < 45)
            send_beat(K_CREATE, ($urandom_range(9) == 0) ? $urandom
                : group_pool[$urandom_range(7)], tid);
        else if (r < 75) send_beat(K_REMOVE, $urandom, 22'($urandom));
        else if (r < 96) send_beat(K_LOOKUP, $urandom, tid);
        else send_beat(K_NONE, $urandom, 22'($urandom));
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) random_beat();
    endtask

    initial begin
        for (int i = 0; i < 8; i++) group_pool[i] = $urandom;
        group_pool[0] = 32'h0;
        group_pool[1] = 32'hFFFF_FFFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty ring, misses, extremes, duplicates and full storage.
        send_beat(K_REMOVE, 32'h0, 22'h0);
        send_beat(K_LOOKUP, 32'h0, 22'h3F_FFFF);
        send_beat(K_NONE, 32'hFFFF_FFFF, 22'h3F_FFFF);
        send_beat(K_CREATE, 32'h0, 22'h0);
        send_beat(K_CREATE, 32'hFFFF_FFFF, 22'h3F_FFFF);
        send_beat(K_CREATE, 32'h0, 22'h3F_FFFF);
        send_beat(K_LOOKUP, 32'h0, 22'h3F_FFFF);
        send_beat(K_LOOKUP, 32'h0, 22'h12345);
        send_beat(K_REMOVE, 32'h0, 22'h0);
        send_beat(K_REMOVE, 32'h0, 22'h0);
        send_beat(K_REMOVE, 32'h0, 22'h0);
        send_beat(K_REMOVE, 32'h0, 22'h0);
        // Fill all group slots, then ask for one more group.
        for (int i = 0; i < MAX_GROUPS + 1; i++) send_beat(K_CREATE, 32'(i), 22'(i));
        // Fill all task slots, then one more task.
        for (int i = 0; i < MAX_TASKS - MAX_GROUPS + 1; i++)
            send_beat(K_CREATE, 32'(i % 4), 22'(i));
        send_beat(K_LOOKUP, 32'h0, 22'h3F_FFFF);
        repeat (MAX_TASKS + 4) send_beat(K_REMOVE, 32'h0, 22'h0);

        run_phase(0, 0, 200);
        run_phase(62, 0, 150);
        run_phase(0, 62, 150);
        run_phase(28, 28, 150);

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            run_phase(0, 0, 20);
        join
        run_phase(0, 0, 30);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (3 * MAX_GROUPS + MAX_TASKS + 20) @(posedge i_clk);
        $display("Sent %0d beats of every kind, %0d results checked, over several",
            items_sent, results_seen);
        $display("idle and stall mixes including full storage and a long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rrgtq_pkg.sv
rtl/rrgtq_store.sv
rtl/rrgtq_ctrl.sv
rtl/round_robin_group_task_queue.sv
verif/round_robin_group_task_queue_checker.sv
verif/round_robin_group_task_queue_test.sv
